// ===== rtl/gbts_pkg.sv =====
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and constants for the gap-buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int CMD_W     = 2;
  localparam int POS_W     = 11;
  localparam int CHAR_W    = 8;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_MOVE      = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_RDW,
    S_DONE
  } state_t;

  // Declared from the top bit down so the packed form matches out_tdata.
  typedef struct packed {
    logic [POS_W-1:0]  text_length;
    logic [POS_W-1:0]  cursor;
    logic [CHAR_W-1:0] char_out;
    status_t           status;
  } result_t;

endpackage

// ===== rtl/gbts_ram.sv =====
// ----------------------------------------------------------------------------
// gbts_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gbts_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbts_ctrl
// Command sequencer: gap pointers, byte shifting across the gap, store access.
// ----------------------------------------------------------------------------
module gbts_ctrl import gbts_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  input  logic [POS_W-1:0]  position,
  input  logic [CHAR_W-1:0] char_in,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [CHAR_W-1:0] ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  logic [CHAR_W-1:0] ram_rdata
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = (PW > POS_W) ? PW : POS_W;

  state_t            state_r, state_nxt;
  logic [PW-1:0]     gs_r, gs_nxt;
  logic [PW-1:0]     ge_r, ge_nxt;
  logic [PW-1:0]     tgt_r, tgt_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  status_t           status_r, status_nxt;
  logic [CHAR_W-1:0] cout_r, cout_nxt;
  logic              wp_r, wp_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;

  logic [PW-1:0] gap_sz, len, gs_dec, ge_dec;
  logic [CW-1:0] pos_ext, len_ext, rd_full;
  logic          step_left, step_right;

  assign gap_sz  = ge_r - gs_r;
  assign len     = PW'(CAPACITY) - gap_sz;
  assign gs_dec  = gs_r - PW'(1);
  assign ge_dec  = ge_r - PW'(1);
  assign pos_ext = CW'(position);
  assign len_ext = CW'(len);
  assign rd_full = (pos_ext < CW'(gs_r)) ? pos_ext : pos_ext + CW'(gap_sz);

  assign step_left  = tgt_r < gs_r;
  assign step_right = (tgt_r > gs_r) && (ge_r < PW'(CAPACITY));

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    gs_nxt     = gs_r;
    ge_nxt     = ge_r;
    tgt_nxt    = tgt_r;
    cmd_nxt    = cmd_r;
    ch_nxt     = ch_r;
    status_nxt = status_r;
    cout_nxt   = cout_r;
    wp_nxt     = 1'b0;
    wa_nxt     = wa_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          status_nxt = ST_OK;
          cout_nxt   = '0;
          cmd_nxt    = cmd;
          ch_nxt     = char_in;
          tgt_nxt    = (pos_ext > len_ext) ? len : PW'(position);
          unique case (cmd)
            CMD_INSERT: begin
              if (gs_r == ge_r) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_MOVE;
              end
            end
            CMD_BACKSPACE: begin
              if (gs_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                gs_nxt = gs_dec;
              end
              state_nxt = S_DONE;
            end
            CMD_MOVE: state_nxt = S_MOVE;
            CMD_READ: begin
              if (pos_ext >= len_ext) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_RDW;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_MOVE: begin
        // one byte per cycle: read now, write it back next cycle
        if (step_left) begin
          gs_nxt = gs_dec;
          ge_nxt = ge_dec;
          wp_nxt = 1'b1;
          wa_nxt = ge_dec[AW-1:0];
        end else if (step_right) begin
          gs_nxt = gs_r + PW'(1);
          ge_nxt = ge_r + PW'(1);
          wp_nxt = 1'b1;
          wa_nxt = gs_r[AW-1:0];
        end else if (!wp_r) begin
          if (cmd_r == CMD_INSERT) begin
            gs_nxt = gs_r + PW'(1);
          end
          state_nxt = S_DONE;
        end
      end
      S_RDW: begin
        cout_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_ready       = (state_r == S_IDLE);
    res_valid       = (state_r == S_DONE);
    res.status      = status_r;
    res.char_out    = cout_r;
    res.cursor      = POS_W'(gs_r);
    res.text_length = POS_W'(len);
    ram_we          = 1'b0;
    ram_waddr       = wa_r;
    ram_wdata       = ram_rdata;
    ram_raddr       = rd_full[AW-1:0];
    if (state_r == S_MOVE) begin
      if (wp_r) begin
        ram_we = 1'b1;
      end else if (!step_left && !step_right && cmd_r == CMD_INSERT) begin
        ram_we    = 1'b1;
        ram_waddr = gs_r[AW-1:0];
        ram_wdata = ch_r;
      end
      if (step_left) begin
        ram_raddr = gs_dec[AW-1:0];
      end else begin
        ram_raddr = ge_r[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gs_r    <= '0;
      ge_r    <= PW'(CAPACITY);
      wp_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gs_r    <= gs_nxt;
      ge_r    <= ge_nxt;
      wp_r    <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r    <= tgt_nxt;
    cmd_r    <= cmd_nxt;
    ch_r     <= ch_nxt;
    status_r <= status_nxt;
    cout_r   <= cout_nxt;
    wa_r     <= wa_nxt;
  end

  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    gs_r <= ge_r) else $error("gap start past gap end");

  a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ge_r <= PW'(CAPACITY)) else $error("gap end past capacity");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_MOVE) else $error("store write outside a move");

  a_shift_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE && state_nxt == S_MOVE) |=> $stable(ge_r - gs_r))
    else $error("gap size changed while shifting");

  a_pending_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE && state_nxt == S_DONE) |-> !wp_r)
    else $error("move finished with a write pending");

endmodule

// ===== rtl/gap_buffer_text_store.sv =====
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Fixed-capacity gap-buffer text store with insert, backspace, move, read.
// ----------------------------------------------------------------------------
// Sequence: backspace and refused commands go straight to the result; read
//   waits on the registered store read; insert and move shift bytes first.
// Throughput: one command at a time; a move shifts one byte per cycle,
//   bounded by the single write port of the text memory (up to CAPACITY).
// Reset: rst_n synchronous, active low; cursor 0, text empty. Text memory is
//   not cleared; only written bytes are ever read back.
module gap_buffer_text_store import gbts_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cmd[1:0], position[12:2], char_in[20:13]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[1:0], char_out[9:2],
                                            // cursor[20:10], text_length[31:21]
);

  localparam int AW = $clog2(CAPACITY);

  logic              res_valid, res_ready;
  result_t           res;
  result_t           out_r;
  logic              out_valid_r;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  gbts_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd_t'(in_tdata[1:0])),
    .position  (in_tdata[12:2]),
    .char_in   (in_tdata[20:13]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  gbts_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_text (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register decouples the sequencer from the result stream
  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gap_buffer_text_store. A directed table covers the
// empty store, clamped positions and refused commands. Random command mixes
// then run on short text, the store is filled to capacity, and more random
// mixes run on long text. Every result is scored against a local gap-buffer
// predictor, with random idle bursts on both streams and two long output
// stalls.
// ----------------------------------------------------------------------------
module tb;
  import gbts_pkg::*;

  localparam int CAP = 1024;

  typedef struct {
    cmd_t             cmd;
    logic [POS_W-1:0] pos;
    logic [CHAR_W-1:0] ch;
    bit               typed;
    result_t          want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor state: text cells and gap bounds
  logic [CHAR_W-1:0] text_mem [CAP];
  int                gap_lo;
  int                gap_hi;

  result_t expected_q [$];
  int      n_sent;
  int      n_results;
  int      n_errors;
  int      n_by_cmd [4];
  int      n_full;
  int      n_empty;
  int      n_range;
  bit      quiet;

  gap_buffer_text_store #(.CAPACITY(CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("gap_buffer_text_store test failed");
    $finish;
  end

  function automatic int held_bytes();
    return CAP - (gap_hi - gap_lo);
  endfunction

  function automatic void slide_gap(int target);
    if (target > held_bytes()) target = held_bytes();
    while (target < gap_lo) begin
      gap_lo--;
      gap_hi--;
      text_mem[gap_hi] = text_mem[gap_lo];
    end
    while (target > gap_lo && gap_hi < CAP) begin
      text_mem[gap_lo] = text_mem[gap_hi];
      gap_lo++;
      gap_hi++;
    end
  endfunction

  function automatic result_t apply_cmd(cmd_t c, int p, logic [CHAR_W-1:0] ch);
    result_t r;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_INSERT: begin
        if (gap_lo >= gap_hi) begin
          r.status = ST_FULL;
        end else begin
          slide_gap(p);
          text_mem[gap_lo] = ch;
          gap_lo++;
        end
      end
      CMD_BACKSPACE: begin
        if (gap_lo == 0) r.status = ST_EMPTY;
        else gap_lo--;
      end
      CMD_MOVE: slide_gap(p);
      CMD_READ: begin
        if (p >= held_bytes()) r.status = ST_RANGE;
        else if (p < gap_lo) r.char_out = text_mem[p];
        else r.char_out = text_mem[p + gap_hi - gap_lo];
      end
    endcase
    r.cursor      = gap_lo[POS_W-1:0];
    r.text_length = POS_W'(held_bytes());
    return r;
  endfunction

  function automatic result_t res(status_t s, logic [CHAR_W-1:0] ch, int cur, int len);
    result_t r;
    r.status      = s;
    r.char_out    = ch;
    r.cursor      = POS_W'(cur);
    r.text_length = POS_W'(len);
    return r;
  endfunction

  // Drive one command and wait for its transaction; predicted or typed
  // expectation is queued at the accepting edge.
  task automatic issue(input cmd_t c, input logic [POS_W-1:0] p,
                       input logic [CHAR_W-1:0] ch, input bit typed,
                       input result_t want);
    result_t pred;
    if (!quiet && (n_sent / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, ch, p, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = apply_cmd(c, int'(p), ch);
    expected_q.push_back(typed ? want : pred);
    n_sent++;
    n_by_cmd[int'(c)]++;
    if (pred.status == ST_FULL) n_full++;
    if (pred.status == ST_EMPTY) n_empty++;
    if (pred.status == ST_RANGE) n_range++;
  endtask

  task automatic random_item(input bit grow);
    int   w;
    int   p;
    int   len;
    cmd_t c;
    len = held_bytes();
    w = $urandom_range(0, 99);
    if (w < (grow ? 45 : 10)) c = CMD_INSERT;
    else if (w < (grow ? 55 : 50)) c = CMD_BACKSPACE;
    else if (w < 75) c = CMD_MOVE;
    else c = CMD_READ;
    w = $urandom_range(0, 9);
    if (w < 5) begin
      p = gap_lo + int'($urandom_range(0, 32)) - 16;
      if (p < 0) p = 0;
    end else if (w < 8) begin
      p = $urandom_range(0, len);
    end else if (w < 9) begin
      p = $urandom_range(0, 2047);
    end else begin
      p = ($urandom_range(0, 1) != 0) ? 0 : len;
    end
    issue(c, p[POS_W-1:0], 8'($urandom), 1'b0, '0);
  endtask

  // output side: scoreboard plus ready pattern
  initial begin : sink
    int      idle_left;
    int      hold_left;
    int      cyc;
    bit      hold_pending;
    result_t got;
    result_t want;
    idle_left    = 0;
    hold_left    = 0;
    cyc          = 0;
    hold_pending = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        n_results++;
        if (n_results == 100 || n_results == 800) hold_pending = 1'b1;
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result, out_tdata=%h", out_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.char_out !== want.char_out ||
              got.cursor !== want.cursor || got.text_length !== want.text_length) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result %0d: exp st=%0d ch=%h cur=%0d len=%0d, got st=%0d ch=%h cur=%0d len=%0d",
                       n_results, want.status, want.char_out, want.cursor,
                       want.text_length, got.status, got.char_out, got.cursor,
                       got.text_length);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (idle_left > 0) begin
        idle_left--;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = 300;
      end else if (!quiet && (cyc / 256) % 3 != 2 && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(1, 6);
      end
      out_tready <= (hold_left == 0 && idle_left == 0);
    end
  end

  initial begin : stimulus
    dir_row_t directed [];
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    quiet      = 1'b0;
    n_sent     = 0;
    n_results  = 0;
    n_errors   = 0;
    n_full     = 0;
    n_empty    = 0;
    n_range    = 0;
    foreach (n_by_cmd[i]) n_by_cmd[i] = 0;
    foreach (text_mem[i]) text_mem[i] = '0;
    gap_lo = 0;
    gap_hi = CAP;

    directed = '{
      '{CMD_READ,      11'd0,    8'h00, 1'b1, res(ST_RANGE, 8'h00, 0, 0)},
      '{CMD_BACKSPACE, 11'd2047, 8'hFF, 1'b1, res(ST_EMPTY, 8'h00, 0, 0)},
      '{CMD_MOVE,      11'd2047, 8'h00, 1'b1, res(ST_OK,    8'h00, 0, 0)},
      '{CMD_INSERT,    11'd2047, 8'hFF, 1'b1, res(ST_OK,    8'h00, 1, 1)},
      '{CMD_INSERT,    11'd0,    8'h00, 1'b1, res(ST_OK,    8'h00, 1, 2)},
      '{CMD_READ,      11'd0,    8'h00, 1'b1, res(ST_OK,    8'h00, 1, 2)},
      '{CMD_READ,      11'd1,    8'h00, 1'b1, res(ST_OK,    8'hFF, 1, 2)},
      '{CMD_READ,      11'd2,    8'h00, 1'b1, res(ST_RANGE, 8'h00, 1, 2)},
      '{CMD_INSERT,    11'd1024, 8'hA5, 1'b1, res(ST_OK,    8'h00, 3, 3)},
      '{CMD_INSERT,    11'd1,    8'h5A, 1'b1, res(ST_OK,    8'h00, 2, 4)},
      '{CMD_MOVE,      11'd1024, 8'h00, 1'b1, res(ST_OK,    8'h00, 4, 4)},
      '{CMD_READ,      11'd1,    8'h00, 1'b1, res(ST_OK,    8'h5A, 4, 4)},
      '{CMD_BACKSPACE, 11'd0,    8'h00, 1'b1, res(ST_OK,    8'h00, 3, 3)},
      '{CMD_MOVE,      11'd0,    8'h00, 1'b1, res(ST_OK,    8'h00, 0, 3)},
      '{CMD_BACKSPACE, 11'd5,    8'h00, 1'b1, res(ST_EMPTY, 8'h00, 0, 3)},
      '{CMD_READ,      11'd2,    8'h00, 1'b1, res(ST_OK,    8'hFF, 0, 3)},
      '{CMD_READ,      11'd3,    8'h00, 1'b1, res(ST_RANGE, 8'h00, 0, 3)},
      '{CMD_READ,      11'd2047, 8'h00, 1'b1, res(ST_RANGE, 8'h00, 0, 3)},
      '{CMD_INSERT,    11'd1,    8'h81, 1'b0, '0},
      '{CMD_MOVE,      11'd3,    8'h00, 1'b0, '0},
      '{CMD_READ,      11'd3,    8'h00, 1'b0, '0},
      '{CMD_MOVE,      11'd1,    8'h00, 1'b0, '0},
      '{CMD_READ,      11'd0,    8'h00, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      issue(directed[i].cmd, directed[i].pos, directed[i].ch,
            directed[i].typed, directed[i].want);

    // short text, mostly growing
    for (int i = 0; i < 290; i++) random_item((i / 50) % 4 != 3);

    // fill to capacity by appending, then hit the full store
    while (held_bytes() < CAP) issue(CMD_INSERT, 11'h7FF, 8'($urandom), 1'b0, '0);
    issue(CMD_INSERT, 11'd0,    8'h3C, 1'b1, res(ST_FULL, 8'h00, CAP, CAP));
    issue(CMD_MOVE,   11'd512,  8'h00, 1'b0, '0);
    issue(CMD_INSERT, 11'd100,  8'hC3, 1'b1, res(ST_FULL, 8'h00, 512, CAP));
    issue(CMD_READ,   11'd1023, 8'h00, 1'b0, '0);
    issue(CMD_READ,   11'd1024, 8'h00, 1'b1, res(ST_RANGE, 8'h00, 512, CAP));
    issue(CMD_BACKSPACE, 11'd0, 8'h00, 1'b0, '0);

    // long text, mostly shrinking; no idling at the tail
    for (int i = 0; i < 290; i++) begin
      if (i >= 230) quiet = 1'b1;
      random_item((i / 50) % 4 == 3);
    end
    in_tvalid <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (40) @(posedge clk);

    $display("commands: %0d insert, %0d backspace, %0d move, %0d read; %0d results scored",
             n_by_cmd[0], n_by_cmd[1], n_by_cmd[2], n_by_cmd[3], n_results);
    $display("refusals seen: %0d store full, %0d nothing to delete, %0d read past end",
             n_full, n_empty, n_range);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("gap_buffer_text_store test passed");
    end else begin
      $display("gap_buffer_text_store test failed");
    end
    $finish;
  end

endmodule

// ===== gap_buffer_text_store.f =====
rtl/gbts_pkg.sv
rtl/gbts_ram.sv
rtl/gbts_ctrl.sv
rtl/gap_buffer_text_store.sv
verif/tb.sv
